[src/shirr_pkg.sv]
`timescale 1ns / 1ps
// Package with the types, constants and tables shared by the irradiance evaluator.
package shirr_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int SLOTS        = 9;
    localparam int OUT_CH       = 3;
    localparam int EVAL_CH      = (NUM_CHANNELS < OUT_CH) ? NUM_CHANNELS : OUT_CH;
    localparam int STORE_DEPTH  = SLOTS * NUM_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int COEF_W = 18;
    localparam int NRM_W  = 16;
    localparam int RES_W  = 21;
    localparam int K_W    = 15;
    localparam int Q_W    = 18;
    localparam int A_W    = 18;
    localparam int T_W    = 33;
    localparam int P_W    = A_W + T_W;
    localparam int ACC_W  = 55;
    localparam int N_QUAD = 5;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [3:0] SL_L00  = 4'd0;
    localparam logic [3:0] SL_L1M1 = 4'd1;
    localparam logic [3:0] SL_L10  = 4'd2;
    localparam logic [3:0] SL_L11  = 4'd3;
    localparam logic [3:0] SL_L2M2 = 4'd4;
    localparam logic [3:0] SL_L2M1 = 4'd5;
    localparam logic [3:0] SL_L20  = 4'd6;
    localparam logic [3:0] SL_L21  = 4'd7;
    localparam logic [3:0] SL_L22  = 4'd8;

    localparam logic [2:0] Q_XY   = 3'd0;
    localparam logic [2:0] Q_XZ   = 3'd1;
    localparam logic [2:0] Q_YZ   = 3'd2;
    localparam logic [2:0] Q_DIFF = 3'd3;
    localparam logic [2:0] Q_ZZ   = 3'd4;

    localparam logic [K_W-1:0] K0   = 15'd7029;
    localparam logic [K_W-1:0] K0X2 = 15'd14058;
    localparam logic [K_W-1:0] K1X2 = 15'd16766;
    localparam logic [K_W-1:0] K2   = 15'd14520;
    localparam logic [K_W-1:0] K3X3 = 15'd12175;

    localparam logic signed [T_W-1:0] ONE_Q14 = T_W'(16384);
    localparam logic signed [T_W-1:0] K3_OFF  = T_W'(4058 * 16384);

    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(1048575);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-1048576);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_QUAD,
        OP_SCALE,
        OP_MAC
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUAD,
        ST_SCALE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [3:0]        idx;
        logic [1:0]        ch;
        logic [ADDR_W-1:0] addr;
        logic              first;
        logic              last;
        logic              clear;
    } t_ctl;

    function automatic logic [K_W-1:0] scale_k(input logic [3:0] slot);
        logic [K_W-1:0] k;
        case (slot)
            SL_L00:  k = K2;
            SL_L1M1: k = K1X2;
            SL_L10:  k = K1X2;
            SL_L11:  k = K1X2;
            SL_L2M2: k = K0X2;
            SL_L2M1: k = K0X2;
            SL_L20:  k = K3X3;
            SL_L21:  k = K0X2;
            SL_L22:  k = K0;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

[src/shirr_coef_store.sv]
`timescale 1ns / 1ps
// Coefficient register file, cleared at reset, one write and one read port.
module shirr_coef_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [shirr_pkg::ADDR_W-1:0]        i_waddr,
    input  logic signed [shirr_pkg::COEF_W-1:0] i_wdata,
    input  logic [shirr_pkg::ADDR_W-1:0]        i_raddr,
    output logic signed [shirr_pkg::COEF_W-1:0] o_rdata
);
    import shirr_pkg::*;

    logic signed [COEF_W-1:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

[src/shirr_seq.sv]
`timescale 1ns / 1ps
// Sequencer that steps the shared multiplier through one evaluation.
module shirr_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_free,
    output logic             o_idle,
    output logic             o_done,
    output shirr_pkg::t_ctl  o_ctl
);
    import shirr_pkg::*;

    t_state            r_state, n_state;
    logic [3:0]        r_cnt, n_cnt;
    logic [1:0]        r_ch, n_ch;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ch    <= '0;
            r_addr  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
            r_addr  <= n_addr;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ch    = r_ch;
        n_addr  = r_addr;
        n_drain = r_drain;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_QUAD;
                    n_cnt   = '0;
                end
            end
            ST_QUAD: begin
                if (r_cnt == 4'(N_QUAD - 1)) begin
                    n_state = ST_SCALE;
                    n_cnt   = SL_L00;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_SCALE: begin
                if (r_cnt == SL_L22) begin
                    n_state = ST_MAC;
                    n_cnt   = SL_L00;
                    n_ch    = '0;
                    n_addr  = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_MAC: begin
                n_addr = r_addr + ADDR_W'(1);
                if (r_cnt == SL_L22) begin
                    n_cnt = SL_L00;
                    if (r_ch == 2'(EVAL_CH - 1)) begin
                        n_state = ST_DRAIN;
                        n_drain = 1'b0;
                    end else begin
                        n_ch = r_ch + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_DONE;
                end else begin
                    n_drain = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.op    = OP_NONE;
        o_ctl.idx   = r_cnt;
        o_ctl.ch    = r_ch;
        o_ctl.addr  = r_addr;
        o_ctl.first = (r_cnt == SL_L00);
        o_ctl.last  = (r_cnt == SL_L22);
        o_idle      = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle      = 1'b1;
                o_ctl.clear = i_start;
            end
            ST_QUAD: begin
                o_ctl.op = OP_QUAD;
            end
            ST_SCALE: begin
                o_ctl.op = OP_SCALE;
            end
            ST_MAC: begin
                o_ctl.op = OP_MAC;
            end
            ST_DONE: begin
                o_done = i_out_free;
            end
            default: begin
                o_ctl.op = OP_NONE;
            end
        endcase
    end

endmodule

[src/shirr_dp.sv]
`timescale 1ns / 1ps
// Datapath with the shared multiplier, term registers, accumulator and saturation.
module shirr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  shirr_pkg::t_ctl                     i_ctl,
    input  logic signed [shirr_pkg::NRM_W-1:0]  i_nx,
    input  logic signed [shirr_pkg::NRM_W-1:0]  i_ny,
    input  logic signed [shirr_pkg::NRM_W-1:0]  i_nz,
    input  logic signed [shirr_pkg::COEF_W-1:0] i_coef,
    output logic signed [shirr_pkg::RES_W-1:0]  o_res_red,
    output logic signed [shirr_pkg::RES_W-1:0]  o_res_green,
    output logic signed [shirr_pkg::RES_W-1:0]  o_res_blue,
    output logic                                o_sat
);
    import shirr_pkg::*;

    localparam logic signed [P_W-1:0]   RND14 = P_W'(1) << 13;
    localparam logic signed [ACC_W-1:0] RND28 = ACC_W'(1) << 27;

    logic signed [A_W-1:0]   w_a;
    logic signed [T_W-1:0]   w_b;
    logic signed [T_W-1:0]   w_src;
    logic signed [P_W-1:0]   w_p;
    logic signed [NRM_W:0]   w_xpy;
    logic signed [NRM_W:0]   w_xmy;
    logic signed [P_W-1:0]   w_q_full;
    logic signed [ACC_W-1:0] w_pext;
    logic signed [ACC_W-1:0] w_acc_next;
    logic signed [ACC_W-1:0] w_rs;
    logic signed [RES_W-1:0] w_sat_val;
    logic                    w_clip;

    logic signed [P_W-1:0]   r_prod;
    t_ctl                    r_wb;
    logic signed [Q_W-1:0]   r_q [N_QUAD];
    logic signed [T_W-1:0]   r_t [SLOTS];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_sum;
    logic                    r_fin;
    logic [1:0]              r_fin_ch;
    logic signed [RES_W-1:0] r_res [OUT_CH];
    logic [OUT_CH-1:0]       r_clip;

    assign w_xpy = (NRM_W + 1)'(i_nx) + (NRM_W + 1)'(i_ny);
    assign w_xmy = (NRM_W + 1)'(i_nx) - (NRM_W + 1)'(i_ny);

    always_comb begin
        case (i_ctl.idx)
            SL_L00:  w_src = ONE_Q14;
            SL_L1M1: w_src = T_W'(i_ny);
            SL_L10:  w_src = T_W'(i_nz);
            SL_L11:  w_src = T_W'(i_nx);
            SL_L2M2: w_src = T_W'(r_q[Q_XY]);
            SL_L2M1: w_src = T_W'(r_q[Q_YZ]);
            SL_L20:  w_src = T_W'(r_q[Q_ZZ]);
            SL_L21:  w_src = T_W'(r_q[Q_XZ]);
            SL_L22:  w_src = T_W'(r_q[Q_DIFF]);
            default: w_src = '0;
        endcase
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_ctl.op)
            OP_QUAD: begin
                case (i_ctl.idx[2:0])
                    Q_XY: begin
                        w_a = A_W'(i_nx);
                        w_b = T_W'(i_ny);
                    end
                    Q_XZ: begin
                        w_a = A_W'(i_nx);
                        w_b = T_W'(i_nz);
                    end
                    Q_YZ: begin
                        w_a = A_W'(i_ny);
                        w_b = T_W'(i_nz);
                    end
                    Q_DIFF: begin
                        w_a = A_W'(w_xpy);
                        w_b = T_W'(w_xmy);
                    end
                    Q_ZZ: begin
                        w_a = A_W'(i_nz);
                        w_b = T_W'(i_nz);
                    end
                    default: begin
                        w_a = '0;
                        w_b = '0;
                    end
                endcase
            end
            OP_SCALE: begin
                w_a = A_W'(scale_k(i_ctl.idx));
                w_b = w_src;
            end
            OP_MAC: begin
                w_a = i_coef;
                w_b = r_t[i_ctl.idx];
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_p        = P_W'(w_a) * P_W'(w_b);
    assign w_q_full   = (r_prod + RND14) >>> 14;
    assign w_pext     = ACC_W'(r_prod);
    assign w_acc_next = r_wb.first ? w_pext : (r_acc + w_pext);
    assign w_rs       = (r_sum + RND28) >>> 28;

    always_comb begin
        w_clip    = 1'b0;
        w_sat_val = RES_W'(w_rs);
        if (w_rs > ACC_W'(RES_MAX)) begin
            w_sat_val = RES_MAX;
            w_clip    = 1'b1;
        end else if (w_rs < ACC_W'(RES_MIN)) begin
            w_sat_val = RES_MIN;
            w_clip    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb  <= '0;
            r_fin <= 1'b0;
        end else begin
            r_wb  <= i_ctl;
            r_fin <= (r_wb.op == OP_MAC) && r_wb.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_p;
        if (r_wb.op == OP_QUAD) begin
            r_q[r_wb.idx[2:0]] <= Q_W'(w_q_full);
        end
        if (r_wb.op == OP_SCALE) begin
            if (r_wb.idx == SL_L20) begin
                r_t[r_wb.idx] <= T_W'(r_prod) - K3_OFF;
            end else begin
                r_t[r_wb.idx] <= T_W'(r_prod);
            end
        end
        if (r_wb.op == OP_MAC) begin
            r_acc <= w_acc_next;
            if (r_wb.last) begin
                r_sum    <= w_acc_next;
                r_fin_ch <= r_wb.ch;
            end
        end
        if (i_ctl.clear) begin
            for (int i = 0; i < OUT_CH; i++) begin
                r_res[i] <= '0;
            end
            r_clip <= '0;
        end else if (r_fin) begin
            r_res[r_fin_ch]  <= w_sat_val;
            r_clip[r_fin_ch] <= w_clip;
        end
    end

    assign o_res_red   = r_res[0];
    assign o_res_green = r_res[1];
    assign o_res_blue  = r_res[2];
    assign o_sat       = |r_clip;

endmodule

[src/sh_irradiance_eval.sv]
`timescale 1ns / 1ps
// Top level of the spherical-harmonic irradiance evaluator with stream ports.
//
//  Channel  Direction  Beat contents
//  s_axis   in         tuser: cmd; tdata: coefficient load or normal
//  m_axis   out        tuser: saturated; tdata: red, green, blue irradiance
//
// A load beat never produces an output beat and leaves the block ready for more.
// An evaluate beat makes the block busy until the sequencer has stepped the
// single shared 18 x 33 multiplier, which retires one product per cycle,
// through the quadratic, scale and accumulate steps and handed off the result.
// Synchronous active-low reset clears all coefficients and the control state.
// A result waiting on m_axis does not block loads or the next evaluation; only
// the hand-off of a finished result waits for the output register to drain.
module sh_irradiance_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // coeff_index, color_channel, coeff_value, normal_x, normal_y, normal_z
    input  logic [shirr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // irradiance_red, irradiance_green, irradiance_blue, zero pad
    output logic [shirr_pkg::M_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic [0:0]                    m_axis_tuser
);
    import shirr_pkg::*;

    localparam int LA_W = 6;

    logic                     w_cmd;
    logic [3:0]               w_coeff_index;
    logic [1:0]               w_color_channel;
    logic signed [COEF_W-1:0] w_coeff_value;
    logic signed [NRM_W-1:0]  w_normal_x;
    logic signed [NRM_W-1:0]  w_normal_y;
    logic signed [NRM_W-1:0]  w_normal_z;

    logic                     w_accept;
    logic                     w_eval;
    logic                     w_load;
    logic [LA_W-1:0]          w_lin;
    logic                     w_we;
    logic                     w_idle;
    logic                     w_done;
    logic                     w_out_free;
    t_ctl                     w_ctl;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [RES_W-1:0]  w_red;
    logic signed [RES_W-1:0]  w_green;
    logic signed [RES_W-1:0]  w_blue;
    logic                     w_sat;

    logic signed [NRM_W-1:0]  r_nx;
    logic signed [NRM_W-1:0]  r_ny;
    logic signed [NRM_W-1:0]  r_nz;
    logic                     r_out_valid;
    logic [M_DATA_W-1:0]      r_out_data;
    logic                     r_out_user;

    assign w_cmd           = s_axis_tuser[0];
    assign w_coeff_index   = s_axis_tdata[3:0];
    assign w_color_channel = s_axis_tdata[5:4];
    assign w_coeff_value   = s_axis_tdata[23:6];
    assign w_normal_x      = s_axis_tdata[39:24];
    assign w_normal_y      = s_axis_tdata[55:40];
    assign w_normal_z      = s_axis_tdata[71:56];

    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_eval        = w_accept && (w_cmd == CMD_EVAL);
    assign w_load        = w_accept && (w_cmd == CMD_LOAD);

    assign w_lin = LA_W'(w_color_channel) * LA_W'(SLOTS) + LA_W'(w_coeff_index);
    assign w_we  = w_load && (w_coeff_index < 4'(SLOTS))
                && ({1'b0, w_color_channel} < 3'(NUM_CHANNELS));

    assign w_out_free = !r_out_valid || m_axis_tready;

    shirr_coef_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_lin[ADDR_W-1:0]),
        .i_wdata (w_coeff_value),
        .i_raddr (w_ctl.addr),
        .o_rdata (w_coef)
    );

    shirr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_eval),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_ctl      (w_ctl)
    );

    shirr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_nx        (r_nx),
        .i_ny        (r_ny),
        .i_nz        (r_nz),
        .i_coef      (w_coef),
        .o_res_red   (w_red),
        .o_res_green (w_green),
        .o_res_blue  (w_blue),
        .o_sat       (w_sat)
    );

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_nx <= w_normal_x;
            r_ny <= w_normal_y;
            r_nz <= w_normal_z;
        end
        if (w_done) begin
            r_out_data <= {1'b0, w_blue, w_green, w_red};
            r_out_user <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

`ifndef ASSERT_OFF
    a_eval_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |=> !s_axis_tready)
        else $error("evaluate beat did not make the block busy");

    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> s_axis_tready)
        else $error("load beat left the block busy");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || m_axis_tready))
        else $error("result written over a beat still waiting on m_axis");

    a_sat_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[20:0] == RES_MAX || m_axis_tdata[20:0] == RES_MIN
          || m_axis_tdata[41:21] == RES_MAX || m_axis_tdata[41:21] == RES_MIN
          || m_axis_tdata[62:42] == RES_MAX || m_axis_tdata[62:42] == RES_MIN))
        else $error("saturated flag set with no channel at a limit");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench that drives coefficient loads and normals into the irradiance evaluator.
module tb_top;
    import shirr_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int QUIET_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int QUAD_SHIFT     = 14;
    localparam int SUM_SHIFT      = 28;

    typedef struct packed {
        logic signed [RES_W-1:0] red;
        logic signed [RES_W-1:0] green;
        logic signed [RES_W-1:0] blue;
        logic                    sat;
    } irr_t;

    typedef struct packed {
        logic                     cmd;
        logic [3:0]               slot;
        logic [1:0]               chan;
        logic signed [COEF_W-1:0] value;
        logic signed [NRM_W-1:0]  nx;
        logic signed [NRM_W-1:0]  ny;
        logic signed [NRM_W-1:0]  nz;
        logic                     has_res;
        irr_t                     res;
    } row_t;

    localparam irr_t ZERO_IRR = '0;

    // The first rows run on the cleared store, so their results are known to be zero.
    row_t dir_tab [25] = '{
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       16'sd16384,  16'sd0,      16'sd0,     1'b1, ZERO_IRR},
        '{CMD_EVAL, 4'd15,  2'd3, -18'sd1,      16'sh8000,   16'sh8000,   16'sh8000,  1'b1, ZERO_IRR},
        '{CMD_LOAD, SL_L00, 2'd0, 18'sd131071,  -16'sd1,     -16'sd1,     -16'sd1,    1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L00, 2'd1, -18'sd131072, 16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L00, 2'd2, 18'sd4096,    16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd15,  2'd3, 18'sd131071,  16'sd0,      16'sd0,      16'sd16384, 1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L1M1, 2'd0, 18'sd4096,   16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L10, 2'd1, -18'sd4096,   16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L11, 2'd2, 18'sd65536,   16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L20, 2'd2, 18'sd131071,  16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L22, 2'd1, 18'sd100000,  16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       16'sd11585,  -16'sd11585, 16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L2M2, 2'd0, 18'sd131071, 16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L2M1, 2'd0, 18'sd131071, 16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L21, 2'd0, 18'sd131071,  16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L2M2, 2'd1, -18'sd131072, 16'sd0,     16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L2M1, 2'd1, -18'sd131072, 16'sd0,     16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L21, 2'd1, -18'sd131072, 16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       16'sh8000,   16'sh8000,   16'sh8000,  1'b0, ZERO_IRR},
        '{CMD_LOAD, 4'd9,   2'd0, 18'sd5,       16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, 4'd15,  2'd1, -18'sd1,      16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_LOAD, SL_L00, 2'd3, 18'sd77,      16'sd0,      16'sd0,      16'sd0,     1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       16'sd16384,  16'sd16384,  16'sd16384, 1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       16'sd32767,  16'sh8000,   16'sd32767, 1'b0, ZERO_IRR},
        '{CMD_EVAL, 4'd0,   2'd0, 18'sd0,       -16'sd16384, 16'sd0,      16'sd0,     1'b0, ZERO_IRR}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    logic                beat_has_res = 1'b0;
    irr_t                beat_res = '0;

    logic signed [COEF_W-1:0] coef_mem [STORE_DEPTH];
    irr_t                     irr_expected [$];
    int                       mismatches = 0;
    int                       rx_count = 0;
    int                       idle_cycles = 0;
    bit                       tx_idle_on = 1'b1;
    bit                       rx_idle_on = 1'b1;
    bit                       hold_done = 1'b0;

    sh_irradiance_eval dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_sh(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic irr_t eval_irradiance(input logic signed [NRM_W-1:0] nx,
                                             input logic signed [NRM_W-1:0] ny,
                                             input logic signed [NRM_W-1:0] nz);
        irr_t   res;
        longint x, y, z, qxy, qxz, qyz, qdiff, qzz, acc, val;
        longint lc [SLOTS];
        longint k0, k0x2, k1x2, k2, k3x3, one, k3_off;
        k0     = longint'(K0);
        k0x2   = longint'(K0X2);
        k1x2   = longint'(K1X2);
        k2     = longint'(K2);
        k3x3   = longint'(K3X3);
        one    = longint'(ONE_Q14);
        k3_off = longint'(K3_OFF);
        x      = nx;
        y      = ny;
        z      = nz;
        qxy    = round_sh(x * y, QUAD_SHIFT);
        qxz    = round_sh(x * z, QUAD_SHIFT);
        qyz    = round_sh(y * z, QUAD_SHIFT);
        qdiff  = round_sh(x * x - y * y, QUAD_SHIFT);
        qzz    = round_sh(z * z, QUAD_SHIFT);
        res    = '0;
        for (int c = 0; c < OUT_CH; c++) begin
            val = 0;
            if (c < NUM_CHANNELS) begin
                for (int s = 0; s < SLOTS; s++) begin
                    lc[s] = coef_mem[c * SLOTS + s];
                end
                acc = k0 * lc[SL_L22] * qdiff
                    + k0x2 * (lc[SL_L2M2] * qxy + lc[SL_L21] * qxz + lc[SL_L2M1] * qyz)
                    + k3x3 * lc[SL_L20] * qzz
                    + k1x2 * (lc[SL_L11] * x + lc[SL_L1M1] * y + lc[SL_L10] * z)
                    + k2 * lc[SL_L00] * one - k3_off * lc[SL_L20];
                val = round_sh(acc, SUM_SHIFT);
                if (val > RES_MAX) begin
                    val     = RES_MAX;
                    res.sat = 1'b1;
                end else if (val < RES_MIN) begin
                    val     = RES_MIN;
                    res.sat = 1'b1;
                end
            end
            case (c)
                0: res.red = val[RES_W-1:0];
                1: res.green = val[RES_W-1:0];
                default: res.blue = val[RES_W-1:0];
            endcase
        end
        return res;
    endfunction

    task automatic take_input_beat();
        logic [3:0]               slot;
        logic [1:0]               chan;
        logic signed [COEF_W-1:0] value;
        irr_t                     res;
        slot  = s_axis_tdata[3:0];
        chan  = s_axis_tdata[5:4];
        value = s_axis_tdata[23:6];
        if (s_axis_tuser[0] == CMD_LOAD) begin
            if (slot < SLOTS && chan < NUM_CHANNELS) begin
                coef_mem[chan * SLOTS + slot] = value;
            end
        end else begin
            res = eval_irradiance(s_axis_tdata[39:24], s_axis_tdata[55:40],
                                  s_axis_tdata[71:56]);
            irr_expected.push_back(beat_has_res ? beat_res : res);
        end
    endtask

    task automatic check_output_beat();
        irr_t want;
        irr_t got;
        got.red   = m_axis_tdata[20:0];
        got.green = m_axis_tdata[41:21];
        got.blue  = m_axis_tdata[62:42];
        got.sat   = m_axis_tuser[0];
        rx_count++;
        if (irr_expected.size() == 0) begin
            $display("%0t: unexpected output beat %0d %0d %0d sat %0b", $time,
                     got.red, got.green, got.blue, got.sat);
            mismatches++;
        end else begin
            want = irr_expected.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                mismatches++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_input_beat();
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_output_beat();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic row_t rand_row();
        row_t r;
        r.cmd     = ($urandom_range(0, 99) < 45) ? CMD_EVAL : CMD_LOAD;
        r.slot    = 4'($urandom);
        r.chan    = 2'($urandom);
        r.value   = 18'($urandom);
        r.nx      = 16'($urandom);
        r.ny      = 16'($urandom);
        r.nz      = 16'($urandom);
        r.has_res = 1'b0;
        r.res     = '0;
        if ($urandom_range(0, 9) != 0) begin
            r.slot = 4'($urandom_range(0, SLOTS - 1));
            r.chan = 2'($urandom_range(0, NUM_CHANNELS - 1));
        end
        if ($urandom_range(0, 9) < 7) begin
            r.value = 18'(int'($urandom_range(0, 16384)) - 8192);
        end
        if ($urandom_range(0, 9) < 7) begin
            r.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
            r.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
            r.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
        end
        return r;
    endfunction

    task automatic send_row(input row_t r, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.nz, r.ny, r.nx, r.value, r.chan, r.slot};
        s_axis_tuser  <= r.cmd;
        beat_has_res  <= r.has_res;
        beat_res      <= r.res;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            coef_mem[i] = '0;
        end
    end

    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && rx_count >= HOLD_AFTER) begin
                // Stall the output long enough for the block to back up into its input.
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_idle_on && (rx_count / 64) % 4 != 3
                         && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i]) begin
            send_row(dir_tab[i], 1'b1);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                rx_idle_on = 1'b0;
            end
            tx_idle_on = (i < RANDOM_ITEMS - QUIET_ITEMS) && ((i / 150) % 3 != 2);
            send_row(rand_row(), tx_idle_on);
        end
        s_axis_tvalid <= 1'b0;
        while (irr_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sh_irradiance_eval.f]
src/shirr_pkg.sv
src/shirr_coef_store.sv
src/shirr_seq.sv
src/shirr_dp.sv
src/sh_irradiance_eval.sv
verif/tb_top.sv
